/* rtl/mtg_pkg.sv */
package mtg_pkg;

  localparam int unsigned StateWords = 624;
  localparam int unsigned FarOffset  = 397;
  localparam int unsigned PosWidth   = $clog2(StateWords);

  localparam logic [31:0] TwistConst = 32'h9908_b0df;
  localparam logic [31:0] TemperB    = 32'h9d2c_5680;
  localparam logic [31:0] TemperC    = 32'hefc6_0000;
  localparam logic [31:0] FillMult   = 32'd1812433253;
  localparam logic [31:0] MixAMult   = 32'd1664525;
  localparam logic [31:0] MixBMult   = 32'd1566083941;
  localparam logic [31:0] FillSeed   = 32'd19650218;
  localparam logic [31:0] TopBit     = 32'h8000_0000;

  localparam logic CmdSeed = 1'b0;
  localparam logic CmdDraw = 1'b1;

  function automatic logic [31:0] twist(input logic [31:0] a, input logic [31:0] b,
                                        input logic [31:0] far);
    logic [31:0] y;
    y = {a[31], b[30:0]};
    return far ^ (y >> 1) ^ (y[0] ? TwistConst : 32'd0);
  endfunction

  function automatic logic [31:0] temper(input logic [31:0] w);
    logic [31:0] y;
    y = w ^ (w >> 11);
    y = y ^ ((y << 7) & TemperB);
    y = y ^ ((y << 15) & TemperC);
    return y ^ (y >> 18);
  endfunction

endpackage

/* rtl/mtg_cell.sv */
module mtg_cell (
  input  logic        clk_i,
  input  logic        shift_i,
  input  logic [31:0] word_i,
  output logic [31:0] word_o
);
  logic [31:0] word_q;

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      word_q <= word_i;
    end
  end

  assign word_o = word_q;
endmodule

/* rtl/mt19937_generator_core.sv */
// Draw: result registered the cycle after acceptance, one draw per cycle while
// in_stall_o is low. Seed: busy while it fills the 624 words, runs the first mix,
// the second mix, then a rotation that puts word 0 back at the head.
// Throughput is set by the 624-cell word ring, one word per cycle while shifting.
// Reset starts the seed sequence with value zero; input stalls until it ends.
// The ring itself has no reset; the sequencer and output valid reset at once.
module mt19937_generator_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               cmd_i,
  input  logic signed [63:0] seed_value_i,
  input  logic        [5:0]  bit_count_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic        [31:0] random_bits_o
);
  import mtg_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE, ST_FILL, ST_MIXA, ST_MIXB, ST_ROT
  } state_e;

  localparam logic [PosWidth-1:0] LastPos = PosWidth'(StateWords - 1);

  state_e              state_q, state_d;
  logic [PosWidth-1:0] pos_q, pos_d;
  logic [PosWidth-1:0] cnt_q, cnt_d;
  logic                j_q, j_d;
  logic                top_q, top_d;
  logic [31:0]         key0_q, key0_d, key1_q, key1_d;
  logic                two_q, two_d;
  logic                out_valid_q;
  logic [31:0]         out_bits_q;

  logic [31:0] word_w [StateWords];
  logic        shift_w;
  logic [31:0] push_w;
  logic [31:0] mix_w, mult_k, prod_w, key_w;
  logic [63:0] mag_w;
  logic        accept_w;
  logic [5:0]  cnt_sat_w;
  logic [31:0] draw_w;

  for (genvar k = 0; k < StateWords; k++) begin : g_ring
    if (k == StateWords - 1) begin : g_tail
      mtg_cell u_cell (.clk_i, .shift_i(shift_w), .word_i(push_w), .word_o(word_w[k]));
    end else begin : g_body
      mtg_cell u_cell (.clk_i, .shift_i(shift_w), .word_i(word_w[k+1]), .word_o(word_w[k]));
    end
  end

  assign in_stall_o = (state_q != ST_IDLE) || (out_valid_q && out_stall_i);
  assign accept_w   = in_valid_i && !in_stall_o;
  assign mag_w      = seed_value_i[63] ? 64'(-seed_value_i) : 64'(seed_value_i);
  assign cnt_sat_w  = (bit_count_i > 6'd32) ? 6'd32 : bit_count_i;
  assign draw_w     = twist(word_w[0], word_w[1], word_w[FarOffset]);

  assign mix_w  = word_w[StateWords-1] ^ (word_w[StateWords-1] >> 30);
  assign mult_k = (state_q == ST_FILL) ? FillMult :
                  (state_q == ST_MIXA) ? MixAMult : MixBMult;
  assign prod_w = mult_k * mix_w;
  assign key_w  = j_q ? key1_q : key0_q;

  always_comb begin
    state_d = state_q;
    pos_d   = pos_q;
    cnt_d   = cnt_q;
    j_d     = j_q;
    top_d   = top_q;
    key0_d  = key0_q;
    key1_d  = key1_q;
    two_d   = two_q;
    shift_w = 1'b0;
    push_w  = word_w[0];
    case (state_q)
      ST_IDLE: begin
        if (accept_w && cmd_i == CmdSeed) begin
          key0_d  = mag_w[31:0];
          key1_d  = mag_w[63:32];
          two_d   = (mag_w[63:32] != 32'd0);
          j_d     = 1'b0;
          pos_d   = '0;
          state_d = ST_FILL;
        end else if (accept_w && cnt_sat_w != 6'd0) begin
          shift_w = 1'b1;
          push_w  = draw_w;
        end
      end
      ST_FILL: begin
        shift_w = 1'b1;
        push_w  = (pos_q == '0) ? FillSeed : prod_w + 32'(pos_q);
        if (pos_q == LastPos) begin
          cnt_d   = '0;
          state_d = ST_MIXA;
        end
      end
      ST_MIXA: begin
        shift_w = 1'b1;
        if (pos_q == '0) begin
          // pass word 0 through on entry, copy the last word on wrap
          push_w = (cnt_q == '0) ? word_w[0] : word_w[StateWords-1];
        end else begin
          push_w = (word_w[0] ^ prod_w) + key_w + 32'(j_q);
          j_d    = two_q ? !j_q : 1'b0;
          cnt_d  = cnt_q + 1'b1;
          if (cnt_q == LastPos) begin
            cnt_d   = '0;
            state_d = ST_MIXB;
          end
        end
      end
      ST_MIXB: begin
        shift_w = 1'b1;
        if (pos_q == '0) begin
          push_w = word_w[StateWords-1];
        end else begin
          push_w = (word_w[0] ^ prod_w) - 32'(pos_q);
          cnt_d  = cnt_q + 1'b1;
          if (cnt_q == LastPos - 1'b1) begin
            top_d   = 1'b0;
            state_d = ST_ROT;
          end
        end
      end
      ST_ROT: begin
        shift_w = 1'b1;
        if (pos_q == '0) begin
          push_w = TopBit;
          top_d  = 1'b1;
        end
        if (pos_q == LastPos && top_q) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
    if (shift_w) begin
      pos_d = (pos_q == LastPos) ? '0 : pos_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_FILL;
      pos_q       <= '0;
      cnt_q       <= '0;
      j_q         <= 1'b0;
      top_q       <= 1'b0;
      key0_q      <= '0;
      key1_q      <= '0;
      two_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      pos_q   <= pos_d;
      cnt_q   <= cnt_d;
      j_q     <= j_d;
      top_q   <= top_d;
      key0_q  <= key0_d;
      key1_q  <= key1_d;
      two_q   <= two_d;
      if (accept_w && cmd_i == CmdDraw) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_w && cmd_i == CmdDraw) begin
      out_bits_q <= (cnt_sat_w == 6'd0) ? 32'd0 :
                    temper(draw_w) >> (6'd32 - cnt_sat_w);
    end
  end

  assign out_valid_o   = out_valid_q;
  assign random_bits_o = out_bits_q;

`ifndef SYNTHESIS
  a_busy_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != ST_IDLE |-> in_stall_o) else $error("input taken while seeding");
  a_result_from_draw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(accept_w && cmd_i == CmdDraw))
    else $error("result without a draw");
  a_wrap_not_counted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MIXA || state_q == ST_MIXB) && pos_q == '0 |=> cnt_q == $past(cnt_q))
    else $error("wrap step counted as update");
  a_rot_ends_at_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_ROT && state_d == ST_IDLE |=> pos_q == '0)
    else $error("ring head misaligned after seeding");
`endif
endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 100ps

module tb;
  import mtg_pkg::*;

  localparam int unsigned IdleLimit = 20000;

  typedef struct packed {
    logic               cmd;
    logic signed [63:0] seed_value;
    logic        [5:0]  bit_count;
  } gen_item_t;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  logic cmd_i;
  logic signed [63:0] seed_value_i;
  logic [5:0] bit_count_i;
  logic out_valid_o;
  logic out_stall_i;
  logic [31:0] random_bits_o;

  mt19937_generator_core uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .cmd_i        (cmd_i),
    .seed_value_i (seed_value_i),
    .bit_count_i  (bit_count_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .random_bits_o(random_bits_o)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // predictor state
  logic [31:0] mt_words [StateWords];
  int unsigned mt_pos;

  gen_item_t   pending_items[$];
  logic [31:0] expected_bits[$];
  int unsigned mismatch_count;
  int unsigned idle_cycles;

  function automatic void queue_item(input gen_item_t it);
    pending_items.insert(pending_items.size(), it);
  endfunction

  function automatic logic [31:0] mix_xor(input logic [31:0] p);
    return p ^ (p >> 30);
  endfunction

  task automatic mt_seed(input logic [63:0] raw);
    logic [63:0] mag;
    logic [31:0] key [2];
    int unsigned klen;
    int unsigned i;
    int unsigned j;
    int unsigned cnt;
    mag = raw[63] ? (~raw + 64'd1) : raw;
    key[0] = mag[31:0];
    key[1] = mag[63:32];
    klen = (key[1] != 0) ? 2 : 1;
    mt_words[0] = FillSeed;
    for (int n = 1; n < StateWords; n++) begin
      mt_words[n] = FillMult * mix_xor(mt_words[n-1]) + 32'(n);
    end
    i = 1;
    j = 0;
    for (cnt = StateWords; cnt > 0; cnt--) begin
      mt_words[i] = (mt_words[i] ^ (mix_xor(mt_words[i-1]) * MixAMult)) + key[j] + 32'(j);
      i++;
      j++;
      if (i >= StateWords) begin
        mt_words[0] = mt_words[StateWords-1];
        i = 1;
      end
      if (j >= klen) j = 0;
    end
    for (cnt = StateWords - 1; cnt > 0; cnt--) begin
      mt_words[i] = (mt_words[i] ^ (mix_xor(mt_words[i-1]) * MixBMult)) - 32'(i);
      i++;
      if (i >= StateWords) begin
        mt_words[0] = mt_words[StateWords-1];
        i = 1;
      end
    end
    mt_words[0] = TopBit;
    mt_pos = StateWords;
  endtask

  task automatic mt_regenerate();
    logic [31:0] y;
    for (int n = 0; n < StateWords; n++) begin
      y = {mt_words[n][31], mt_words[(n + 1) % StateWords][30:0]};
      mt_words[n] = mt_words[(n + FarOffset) % StateWords] ^ (y >> 1) ^
                    (y[0] ? TwistConst : 32'd0);
    end
    mt_pos = 0;
  endtask

  task automatic predict_item(input gen_item_t it);
    int unsigned cnt;
    logic [31:0] y;
    if (it.cmd == CmdSeed) begin
      mt_seed(it.seed_value);
    end else begin
      cnt = (it.bit_count > 32) ? 32 : it.bit_count;
      if (cnt == 0) begin
        expected_bits.insert(expected_bits.size(), 32'd0);
      end else begin
        if (mt_pos >= StateWords) mt_regenerate();
        y = mt_words[mt_pos];
        mt_pos++;
        y = y ^ (y >> 11);
        y = y ^ ((y << 7) & 32'h9d2c_5680);
        y = y ^ ((y << 15) & 32'hefc6_0000);
        y = y ^ (y >> 18);
        expected_bits.insert(expected_bits.size(), y >> (32 - cnt));
      end
    end
  endtask

  function automatic gen_item_t draw_item(input logic [5:0] bc);
    gen_item_t it;
    it.cmd = CmdDraw;
    it.seed_value = {$urandom, $urandom};
    it.bit_count = bc;
    return it;
  endfunction

  function automatic gen_item_t seed_item(input logic [63:0] sv);
    gen_item_t it;
    it.cmd = CmdSeed;
    it.seed_value = sv;
    it.bit_count = 6'($urandom);
    return it;
  endfunction

  // driver: bursts with random gaps
  int unsigned burst_left;
  int unsigned gap_left;
  always @(posedge clk_i or negedge rst_ni) begin
    gen_item_t it;
    logic      take;
    if (!rst_ni) begin
      in_valid_i   <= 1'b0;
      cmd_i        <= CmdDraw;
      seed_value_i <= '0;
      bit_count_i  <= '0;
      burst_left   <= 0;
      gap_left     <= 0;
    end else begin
      take = in_valid_i && !in_stall_o;
      if (take) begin
        predict_item(pending_items.pop_front());
      end
      if (!in_valid_i || take) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid_i <= 1'b0;
        end else if (pending_items.size() > 0) begin
          it = pending_items[0];
          in_valid_i   <= 1'b1;
          cmd_i        <= it.cmd;
          seed_value_i <= it.seed_value;
          bit_count_i  <= it.bit_count;
          if (burst_left == 0) begin
            burst_left <= $urandom_range(1, 30);
            gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // receiver stall pattern and checker
  int unsigned stall_phase;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_phase <= 0;
      mismatch_count <= 0;
      idle_cycles <= 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_bits.size() == 0) begin
          mismatch_count <= mismatch_count + 1;
          if (mismatch_count < 10)
            $display("unexpected item: random_bits=%h", random_bits_o);
        end else if (expected_bits[0] !== random_bits_o) begin
          mismatch_count <= mismatch_count + 1;
          if (mismatch_count < 10)
            $display("random_bits mismatch: exp=%h act=%h", expected_bits[0], random_bits_o);
          void'(expected_bits.pop_front());
        end else begin
          void'(expected_bits.pop_front());
        end
      end
      stall_phase <= stall_phase + 1;
      // quiet stretch, then periodic stalls, then random stalls
      case ((stall_phase / 200) % 3)
        0: out_stall_i <= 1'b0;
        1: out_stall_i <= (stall_phase % 5) < 2;
        default: out_stall_i <= ($urandom_range(0, 2) == 0);
      endcase
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
    end
  end

  always @(posedge clk_i) begin
    if (idle_cycles >= IdleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    logic [5:0] bc;
    int unsigned r;
    mt_seed(64'd0);
    rst_ni = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: default state, bit count extremes, seed extremes
    queue_item(draw_item(6'd32));
    queue_item(draw_item(6'd0));
    queue_item(draw_item(6'd1));
    queue_item(draw_item(6'd31));
    queue_item(draw_item(6'd33));
    queue_item(draw_item(6'd63));
    queue_item(seed_item(64'h8000_0000_0000_0000));
    queue_item(draw_item(6'd32));
    queue_item(draw_item(6'd16));
    queue_item(seed_item(64'h7fff_ffff_ffff_ffff));
    queue_item(draw_item(6'd32));
    queue_item(seed_item(64'hffff_ffff_ffff_ffff));
    queue_item(draw_item(6'd32));
    queue_item(seed_item(64'h0000_0000_ffff_ffff));
    queue_item(draw_item(6'd32));
    queue_item(seed_item(64'h0000_0001_0000_0000));
    queue_item(draw_item(6'd32));
    queue_item(seed_item(64'd0));
    queue_item(draw_item(6'd8));
    queue_item(draw_item(6'd0));

    // random: mostly draws, with a rare reseed
    for (int k = 0; k < 430; k++) begin
      r = $urandom_range(0, 999);
      if (r < 3) begin
        queue_item(seed_item(($urandom_range(0, 1) != 0) ?
                   64'($signed($urandom)) : {$urandom, $urandom}));
      end else begin
        r = $urandom_range(0, 9);
        if (r == 0) bc = 6'd0;
        else if (r == 1) bc = 6'($urandom_range(33, 63));
        else if (r < 6) bc = 6'd32;
        else bc = 6'($urandom_range(1, 31));
        queue_item(draw_item(bc));
      end
    end
    queue_item(draw_item(6'd32));

    wait (pending_items.size() == 0);
    @(posedge clk_i);
    wait (expected_bits.size() == 0);
    repeat (20) @(posedge clk_i);
    if (mismatch_count == 0 && expected_bits.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

/* mt19937_generator_core.f */
rtl/mtg_pkg.sv
rtl/mtg_cell.sv
rtl/mt19937_generator_core.sv
tb/sv/tb.sv
